/* rtl/isotp_receive_reassembly_top_defines.svh */
`ifndef ISOTP_RECEIVE_REASSEMBLY_TOP_DEFINES_SVH
`define ISOTP_RECEIVE_REASSEMBLY_TOP_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define ISOTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ISOTP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/isotp_pkg.sv */
package isotp_pkg;

  localparam int unsigned MAX_MESSAGE = 4095;
  localparam int unsigned BUF_AW      = 12;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned BYTE0_LSB   = 33;

  localparam logic [16:0] IDLE_MAX    = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [11:0] LIMIT_RST   = 12'd4095;

  // configuration register indexes
  localparam logic [1:0] CFG_RX_ID   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  // protocol control information types
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_POLL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_STORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic exec;
    logic store_wr;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic exec_store;
    logic store_last;
  } sts_t;

endpackage

/* rtl/isotp_ctrl.sv */
`include "isotp_receive_reassembly_top_defines.svh"

module isotp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output isotp_pkg::cmd_t cmd_o,
  input  isotp_pkg::sts_t sts_i
);
  import isotp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:  if (s_valid_i) state_d = ST_EXEC;
      ST_EXEC:  state_d = sts_i.exec_store ? ST_STORE : ST_OUT;
      ST_STORE: if (sts_i.store_last) state_d = ST_OUT;
      ST_OUT:   if (m_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    s_ready_o      = 1'b0;
    m_valid_o      = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_wr = 1'b1;
      ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_STORE: cmd_o.store_wr = 1'b1;
      ST_OUT:   m_valid_o = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `ISOTP_ASSERT(a_capture_exec, (s_valid_i && s_ready_o) |=> (state_q == ST_EXEC), "capture did not start exec")
  `ISOTP_ASSERT(a_exec_out, (state_q == ST_EXEC && !sts_i.exec_store) |=> (state_q == ST_OUT), "exec without store skipped result")
  `ISOTP_ASSERT(a_store_end, (state_q == ST_STORE && sts_i.store_last) |=> (state_q == ST_OUT), "store run did not end")
  `ISOTP_ASSERT(a_clear_hold, (state_q == ST_CLEAR && !sts_i.clear_done) |=> (state_q == ST_CLEAR), "clear pass cut short")
  `ISOTP_ASSERT_NEVER(a_rdy_vld, s_ready_o && m_valid_o, "input ready while result pending")

endmodule

/* rtl/isotp_dpath.sv */
module isotp_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [28:0]                           cfg_data_i,
  input  logic [isotp_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic [1:0]                            s_tuser_i,
  output logic [isotp_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  input  isotp_pkg::cmd_t                       cmd_i,
  output isotp_pkg::sts_t                       sts_o
);
  import isotp_pkg::*;

  // configuration
  logic [28:0] rx_id_q;
  logic [15:0] timeout_q;
  logic [11:0] limit_q;

  // latched item
  op_e         op_q;
  logic [28:0] id_q;
  logic [3:0]  len_q;
  logic [7:0]  byte_q [8];
  logic [11:0] ridx_q;

  // receive state
  phase_e      phase_q, phase_d;
  logic [11:0] exp_q, exp_d;
  logic [11:0] cnt_q, cnt_d;
  logic [3:0]  seq_q, seq_d;
  logic [16:0] idle_q, idle_d;

  // byte copy run
  logic [2:0]  src_q, src_d;
  logic [2:0]  rem_q, rem_d;

  // result fields
  logic        cons_q, cons_d;
  logic        sfc_q, sfc_d;
  logic        rdy_q, rdy_d;
  logic [11:0] mlen_q, mlen_d;

  logic [BUF_AW-1:0] clr_addr_q;
  logic [7:0]        mem [2**BUF_AW];
  logic [7:0]        rd_q;

  logic              wr_en;
  logic [BUF_AW-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_id_q   <= '0;
      timeout_q <= TIMEOUT_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RX_ID:   rx_id_q <= cfg_data_i;
        CFG_TIMEOUT: timeout_q <= cfg_data_i[15:0];
        CFG_LIMIT:   limit_q <= cfg_data_i[11:0];
        default: begin
          rx_id_q <= rx_id_q;
        end
      endcase
    end
  end

  // item capture; all fields of the item, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(s_tuser_i);
      id_q   <= s_tdata_i[28:0];
      len_q  <= s_tdata_i[32:29];
      ridx_q <= s_tdata_i[108:97];
      for (int i = 0; i < 8; i++) begin
        byte_q[i] <= s_tdata_i[BYTE0_LSB + 8*i +: 8];
      end
    end
  end

  logic [3:0]  len_eff, lm1, pci, nib;
  logic [11:0] ff_len, room;
  logic [2:0]  k;
  logic [12:0] cnt_sum;

  always_comb begin
    len_eff = (len_q > 4'd8) ? 4'd8 : len_q;
    lm1     = len_eff - 4'd1;
    pci     = byte_q[0][7:4];
    nib     = byte_q[0][3:0];
    ff_len  = {nib, byte_q[1]};
    room    = (exp_q > cnt_q) ? (exp_q - cnt_q) : 12'd0;
    k       = '0;
    cnt_sum = '0;

    phase_d = phase_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    seq_d   = seq_q;
    idle_d  = idle_q;
    src_d   = src_q;
    rem_d   = rem_q;
    cons_d  = cons_q;
    sfc_d   = sfc_q;
    rdy_d   = rdy_q;
    mlen_d  = mlen_q;

    if (cmd_i.exec) begin
      cons_d = 1'b0;
      sfc_d  = 1'b0;
      rdy_d  = 1'b0;
      mlen_d = '0;
      rem_d  = '0;
      unique case (op_q)
        OP_FRAME: begin
          cons_d = (id_q == rx_id_q);
          if (cons_d && len_eff != 4'd0) begin
            unique case (pci)
              PCI_SF: begin
                if (nib != 4'd0 && nib <= 4'd7) begin
                  k       = (lm1 < nib) ? lm1[2:0] : nib[2:0];
                  exp_d   = {8'd0, nib};
                  cnt_d   = '0;
                  src_d   = 3'd1;
                  rem_d   = k;
                  phase_d = PH_DONE;
                  idle_d  = '0;
                end
              end
              PCI_FF: begin
                if (ff_len == 12'd0 || 32'(ff_len) > MAX_MESSAGE) begin
                  phase_d = PH_IDLE;
                end else begin
                  if (len_eff >= 4'd8) begin
                    k = 3'd6;
                  end else if (len_eff >= 4'd2) begin
                    k = 3'(len_eff - 4'd2);
                  end
                  exp_d   = ff_len;
                  cnt_d   = '0;
                  src_d   = 3'd2;
                  rem_d   = k;
                  seq_d   = 4'd1;
                  phase_d = PH_RECV;
                  idle_d  = '0;
                  sfc_d   = 1'b1;
                end
              end
              PCI_CF: begin
                if (phase_q == PH_RECV) begin
                  if (nib != seq_q) begin
                    phase_d = PH_IDLE;
                  end else begin
                    k       = (room < {9'd0, lm1[2:0]}) ? room[2:0] : lm1[2:0];
                    cnt_sum = {1'b0, cnt_q} + {10'd0, k};
                    src_d   = 3'd1;
                    rem_d   = k;
                    seq_d   = seq_q + 4'd1;
                    idle_d  = '0;
                    if (cnt_sum >= {1'b0, exp_q}) phase_d = PH_DONE;
                  end
                end
              end
              default: begin
                phase_d = phase_q;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (idle_q != IDLE_MAX) idle_d = idle_q + 17'd1;
        end
        OP_POLL: begin
          if (phase_q == PH_RECV) begin
            if (idle_q > {1'b0, timeout_q}) phase_d = PH_IDLE;
          end else if (phase_q == PH_DONE) begin
            rdy_d   = 1'b1;
            mlen_d  = (exp_q <= limit_q) ? exp_q : limit_q;
            phase_d = PH_IDLE;
          end
        end
        OP_READ: begin
          phase_d = phase_q;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if (cmd_i.store_wr) begin
      cnt_d = cnt_q + 12'd1;
      src_d = src_q + 3'd1;
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      exp_q      <= '0;
      cnt_q      <= '0;
      seq_q      <= '0;
      idle_q     <= '0;
      src_q      <= '0;
      rem_q      <= '0;
      clr_addr_q <= '0;
    end else begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      seq_q   <= seq_d;
      idle_q  <= idle_d;
      src_q   <= src_d;
      rem_q   <= rem_d;
      if (cmd_i.clear_wr) clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cons_q <= cons_d;
    sfc_q  <= sfc_d;
    rdy_q  <= rdy_d;
    mlen_q <= mlen_d;
  end

  // single write port shared by the clear sweep and byte stores
  always_comb begin
    wr_en   = cmd_i.clear_wr | cmd_i.store_wr;
    wr_addr = cmd_i.clear_wr ? clr_addr_q : cnt_q;
    wr_data = cmd_i.clear_wr ? 8'h00 : byte_q[src_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[ridx_q];
  end

  assign sts_o.clear_done = &clr_addr_q;
  assign sts_o.exec_store = |rem_d;
  assign sts_o.store_last = (rem_q == 3'd1);

  assign m_tdata_o = {7'd0, phase_q, ((op_q == OP_READ) ? rd_q : 8'h00),
                      mlen_q, rdy_q, sfc_q, cons_q};

endmodule

/* rtl/isotp_receive_reassembly_top.sv */
// Result valid after the decode state and then k byte stores, k = payload bytes
// written to the buffer by the item (0..7). A new item is taken only after the
// previous result has been accepted.
// Reset: asynchronous, active low; clears control, receive and configuration
// state; a sweep then zeroes all 4096 buffer entries, taking no item meanwhile.
// Configuration writes are taken in every cycle, including during the sweep.
module isotp_receive_reassembly_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [28:0]                           cfg_data_i,
  // input items
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // frame_id[28:0], frame_len[32:29], byte0[40:33], byte1[48:41],
  // byte2[56:49], byte3[64:57], byte4[72:65], byte5[80:73], byte6[88:81],
  // byte7[96:89], read_index[108:97], zero pad[111:109]
  input  logic [isotp_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]                            s_axis_tuser_i,
  // result items
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // consumed[0], send_flow_control[1], message_ready[2],
  // message_length[14:3], read_data[22:15], receive_status[24:23],
  // zero pad[31:25]
  output logic [isotp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import isotp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: clear sweep, capture, decode, byte stores, result hold
  isotp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // receive state, config registers, message buffer and result register
  isotp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tdata_o   (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
